>>> rtl/daat_pkg.sv
// ----------------------------------------------------------------------------
// daat_pkg
// Shared types and fixed field widths for the device address allow table.
// ----------------------------------------------------------------------------
package daat_pkg;

  localparam int unsigned ADDR_W  = 48;  // device address width
  localparam int unsigned POS_W   = 4;   // position field width
  localparam int unsigned COUNT_W = 5;   // entry count field width

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_REG    = 2'd1,
    CMD_UNREG  = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_DUP    = 2'd1,
    STS_ABSENT = 2'd2,
    STS_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_SHIFT  = 2'd2,
    ST_FINISH = 2'd3
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic start;   // capture item, reset scan pointers
    logic scan;    // step the search sweep
    logic shift;   // step the close-the-gap sweep
    logic finish;  // commit table update, load result register
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic match;       // entry under compare equals the address
    logic need_shift;  // match on an unregister item
    logic sweep_done;  // nothing issued, nothing pending
    logic out_free;    // result register can take a new result
  } stat_t;

endpackage

>>> rtl/daat_cmd_if.sv
// ----------------------------------------------------------------------------
// daat_cmd_if
// Command channel: one item carries a command and a device address.
// ----------------------------------------------------------------------------
interface daat_cmd_if;
  logic                                valid;
  logic                                ready;
  daat_pkg::cmd_e                      command;
  logic [daat_pkg::ADDR_W-1:0]         device_address;

  modport source (output valid, output command, output device_address, input ready);
  modport sink   (input valid, input command, input device_address, output ready);
endinterface

>>> rtl/daat_rsp_if.sv
// ----------------------------------------------------------------------------
// daat_rsp_if
// Response channel: status, position and entry count for one command.
// ----------------------------------------------------------------------------
interface daat_rsp_if;
  logic                                valid;
  logic                                ready;
  daat_pkg::status_e                   status;
  logic [daat_pkg::POS_W-1:0]          position;
  logic [daat_pkg::COUNT_W-1:0]        entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

>>> rtl/device_address_allow_table.sv
// ----------------------------------------------------------------------------
// device_address_allow_table
// Ordered table of 48-bit device addresses with lookup, register, unregister.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one item per command (command, device_address); rsp_o
//   returns exactly one item per command (status, position, entry_count),
//   in order. Both channels use valid/ready; transfer when both are high.
//   One command is worked on at a time. Each item is accepted, then the
//   stored entries are searched in order; an unregister that hits then
//   closes the gap, and the table update and result are committed last.
//   Both sweeps go through the single read port of the address memory:
//   one entry is read per cycle, first to search, then to move later
//   entries down one place. The result sits in an output register; a
//   new command is accepted and searched while the previous result still
//   waits on rsp_o. If the receiver stalls, the sequencer holds before
//   commit until the result register frees, so nothing is lost or
//   overwritten.
//   Reset clears the entry count and all handshakes; the address memory
//   is not cleared, since only entries below the count are ever used.
// ----------------------------------------------------------------------------
module device_address_allow_table #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  daat_cmd_if.sink      cmd_i,
  daat_rsp_if.source    rsp_o
);
  import daat_pkg::*;

  ctrl_t ctl;
  stat_t sts;

  // sequencer
  daat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .stat_i     (sts),
    .ctrl_o     (ctl)
  );

  // memory, count, sweep pointers, result register
  daat_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .command_i        (cmd_i.command),
    .device_address_i (cmd_i.device_address),
    .ctrl_i           (ctl),
    .stat_o           (sts),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .status_o         (rsp_o.status),
    .position_o       (rsp_o.position),
    .entry_count_o    (rsp_o.entry_count)
  );

  // an accepted command keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("command accepted while previous one still in flight");

  // commit always presents a result next cycle
  a_finish_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.finish |=> rsp_o.valid)
    else $error("commit did not load a result");

  // commit only when the result register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.finish |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result overwritten before it was taken");

  // misses and full table report position zero
  a_pos_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == STS_ABSENT || rsp_o.status == STS_FULL))
      |-> (rsp_o.position == '0))
    else $error("nonzero position on a failed command");

endmodule

>>> rtl/daat_datapath.sv
// ----------------------------------------------------------------------------
// daat_datapath
// Address memory, entry count, sweep pointers and the result register.
// ----------------------------------------------------------------------------
module daat_datapath #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  daat_pkg::cmd_e                command_i,
  input  logic [daat_pkg::ADDR_W-1:0]   device_address_i,
  input  daat_pkg::ctrl_t               ctrl_i,
  output daat_pkg::stat_t               stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output daat_pkg::status_e             status_o,
  output logic [daat_pkg::POS_W-1:0]    position_o,
  output logic [daat_pkg::COUNT_W-1:0]  entry_count_o
);
  import daat_pkg::*;

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  logic [ADDR_W-1:0] mem [MAX_ENTRIES];
  logic [ADDR_W-1:0] rd_data_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [ADDR_W-1:0] wd;

  logic [ADDR_W-1:0] addr_q;
  cmd_e              op_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [CNT_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              hit_q, hit_d;
  logic [CNT_W-1:0]  hit_idx_q, hit_idx_d;
  logic              out_valid_q, out_valid_d;
  status_e           res_status_q, res_status_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d;
  logic [COUNT_W-1:0] res_count_q, res_count_d;

  logic              iss;
  logic              match;
  logic [CNT_W-1:0]  back_idx;

  assign iss      = (ptr_q < count_q);
  assign rd_addr  = ptr_q[IDX_W-1:0];
  assign match    = cmp_vld_q && (rd_data_q == addr_q);
  assign back_idx = cmp_idx_q - CNT_W'(1);

  always_comb begin
    count_d      = count_q;
    ptr_d        = ptr_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    out_valid_d  = out_valid_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_count_d  = res_count_q;
    we           = 1'b0;
    wa           = count_q[IDX_W-1:0];
    wd           = addr_q;

    if (ctrl_i.start) begin
      ptr_d     = '0;
      cmp_vld_d = 1'b0;
      hit_d     = 1'b0;
    end

    if (ctrl_i.scan) begin
      if (match) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
        ptr_d     = cmp_idx_q + CNT_W'(1);  // shift starts one past the hit
        cmp_vld_d = 1'b0;
      end else begin
        cmp_vld_d = iss;
        cmp_idx_d = ptr_q;
        ptr_d     = ptr_q + CNT_W'(iss);
      end
    end

    if (ctrl_i.shift) begin
      cmp_vld_d = iss;
      cmp_idx_d = ptr_q;
      ptr_d     = ptr_q + CNT_W'(iss);
      if (cmp_vld_q) begin
        we = 1'b1;
        wa = back_idx[IDX_W-1:0];
        wd = rd_data_q;
      end
    end

    if (ctrl_i.finish) begin
      out_valid_d = 1'b1;
      case (op_q)
        CMD_REG: begin
          if (hit_q) begin
            res_status_d = STS_DUP;
            res_pos_d    = POS_W'(hit_idx_q);
          end else if (count_q == MAX_CNT) begin
            res_status_d = STS_FULL;
            res_pos_d    = '0;
          end else begin
            we           = 1'b1;
            wa           = count_q[IDX_W-1:0];
            wd           = addr_q;
            count_d      = count_q + CNT_W'(1);
            res_status_d = STS_OK;
            res_pos_d    = POS_W'(count_q);
          end
        end
        CMD_UNREG: begin
          if (hit_q) begin
            count_d      = count_q - CNT_W'(1);
            res_status_d = STS_OK;
            res_pos_d    = POS_W'(hit_idx_q);
          end else begin
            res_status_d = STS_ABSENT;
            res_pos_d    = '0;
          end
        end
        default: begin
          res_status_d = hit_q ? STS_OK : STS_ABSENT;
          res_pos_d    = hit_q ? POS_W'(hit_idx_q) : '0;
        end
      endcase
      res_count_d = COUNT_W'(count_d);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      addr_q <= device_address_i;
      op_q   <= command_i;
    end
    cmp_idx_q    <= cmp_idx_d;
    hit_idx_q    <= hit_idx_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_count_q  <= res_count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.match      = match;
  assign stat_o.need_shift = match && (op_q == CMD_UNREG);
  assign stat_o.sweep_done = !cmp_vld_q && !iss;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_status_q;
  assign position_o    = res_pos_q;
  assign entry_count_o = res_count_q;

endmodule

>>> rtl/daat_ctrl.sv
// ----------------------------------------------------------------------------
// daat_ctrl
// Sequencer: accept, search sweep, optional gap-closing sweep, commit.
// ----------------------------------------------------------------------------
module daat_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  daat_pkg::stat_t stat_i,
  output daat_pkg::ctrl_t ctrl_o
);
  import daat_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.match) begin
          state_d = stat_i.need_shift ? ST_SHIFT : ST_FINISH;
        end else if (stat_i.sweep_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_SHIFT: begin
        ctrl_o.shift = 1'b1;
        if (stat_i.sweep_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          ctrl_o.finish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> dv/device_address_allow_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// device_address_allow_table_test
// Self-checking bench for the device address allow table. A short table of
// directed commands covers the empty and full table, duplicates, misses, the
// spare command and gap closing. A long random run follows, with fill, drain
// and mixed phases. Responses are checked against typed rows or a shadow table.
// ----------------------------------------------------------------------------
module device_address_allow_table_test;
  import daat_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 1124;  // plus the directed rows, about 1150
  localparam int unsigned QUIET_ITEMS  = 150;   // tail of the run with no idling
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned POOL_N       = 24;    // more than the depth, so the table can fill
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned IDLE_LIMIT   = 2000;  // cycles with no item moving on either side

  localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

  typedef struct packed {
    status_e             status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  entry_count;
  } allow_rsp_t;

  typedef struct {
    cmd_e               command;
    logic [ADDR_W-1:0]  address;
    bit                 typed;   // expectation written into the row
    allow_rsp_t         want;
  } directed_row_t;

  // Random phases steer how full the table runs.
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  logic clk_i;
  logic rst_ni;

  daat_cmd_if cmd_if ();
  daat_rsp_if rsp_if ();

  device_address_allow_table #(
    .MAX_ENTRIES (TABLE_DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  // Shadow of the table contents and count
  logic [ADDR_W-1:0] shadow_addr [TABLE_DEPTH];
  int unsigned       shadow_count;

  allow_rsp_t        pending_rsp_q [$];
  directed_row_t     directed_q [$];
  logic [ADDR_W-1:0] recent_pool [POOL_N];

  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left;
  bit          quiet;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the response to one command and applies it to the shadow.
  // Matching is on all 48 bits; the spare command behaves as a lookup.
  function automatic allow_rsp_t table_step(cmd_e cmd, logic [ADDR_W-1:0] addr);
    allow_rsp_t rsp;
    int         hit;
    hit = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_addr[i] == addr) hit = i;
    end
    rsp.position = '0;
    case (cmd)
      CMD_REG: begin
        if (hit >= 0) begin
          // duplicate wins over a full table
          rsp.status   = STS_DUP;
          rsp.position = hit[POS_W-1:0];
        end else if (shadow_count >= TABLE_DEPTH) begin
          rsp.status = STS_FULL;
        end else begin
          rsp.status                = STS_OK;
          rsp.position              = shadow_count[POS_W-1:0];
          shadow_addr[shadow_count] = addr;
          shadow_count++;
        end
      end
      CMD_UNREG: begin
        if (hit >= 0) begin
          // close the gap, order of the rest is kept
          for (int i = hit; i + 1 < shadow_count; i++) shadow_addr[i] = shadow_addr[i + 1];
          shadow_count--;
          rsp.status   = STS_OK;
          rsp.position = hit[POS_W-1:0];
        end else begin
          rsp.status = STS_ABSENT;
        end
      end
      default: begin
        if (hit >= 0) begin
          rsp.status   = STS_OK;
          rsp.position = hit[POS_W-1:0];
        end else begin
          rsp.status = STS_ABSENT;
        end
      end
    endcase
    rsp.entry_count = shadow_count[COUNT_W-1:0];
    return rsp;
  endfunction

  function automatic logic [ADDR_W-1:0] random_address();
    logic [ADDR_W-1:0] addr;
    addr[31:0]       = $urandom();
    addr[ADDR_W-1:32] = 16'($urandom_range(0, 16'hFFFF));
    return addr;
  endfunction

  // Mostly stored addresses (hits), near misses one bit off a stored entry,
  // a reused pool that brings back removed addresses, and fresh values.
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] addr;
    int unsigned       sel;
    sel = $urandom_range(0, 99);
    if (shadow_count > 0 && sel < 50) begin
      addr = shadow_addr[$urandom_range(0, shadow_count - 1)];
    end else if (shadow_count > 0 && sel < 65) begin
      addr = shadow_addr[$urandom_range(0, shadow_count - 1)];
      addr[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
    end else if (sel < 85) begin
      addr = recent_pool[$urandom_range(0, POOL_N - 1)];
    end else begin
      addr = random_address();
    end
    return addr;
  endfunction

  function automatic cmd_e pick_command(phase_e phase);
    int unsigned reg_th [3]   = '{50, 15, 35};
    int unsigned unreg_th [3] = '{60, 65, 65};
    int unsigned look_th [3]  = '{92, 92, 93};
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < reg_th[phase])   return CMD_REG;
    if (sel < unreg_th[phase]) return CMD_UNREG;
    if (sel < look_th[phase])  return CMD_LOOKUP;
    return CMD_SPARE;
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  task automatic add_row(cmd_e cmd, logic [ADDR_W-1:0] addr, bit typed,
                         status_e status, int unsigned pos, int unsigned count);
    directed_row_t row;
    row.command          = cmd;
    row.address          = addr;
    row.typed            = typed;
    row.want.status      = status;
    row.want.position    = pos[POS_W-1:0];
    row.want.entry_count = count[COUNT_W-1:0];
    directed_q.push_back(row);
  endtask

  // Drives one command item, with an optional gap in front of it. The
  // expectation is queued at the edge where the item is taken.
  task automatic send_item(cmd_e cmd, logic [ADDR_W-1:0] addr, bit typed, allow_rsp_t want);
    allow_rsp_t predicted;
    int unsigned gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_if.valid          <= 1'b1;
    cmd_if.command        <= cmd;
    cmd_if.device_address <= addr;
    do @(posedge clk_i); while (!cmd_if.ready);
    predicted = table_step(cmd, addr);
    pending_rsp_q.push_back(typed ? want : predicted);
  endtask

  // Response side: ready drops in bursts
  initial begin
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Response check and watchdog
  always @(posedge clk_i) begin
    allow_rsp_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected response: status %0d position %0d count %0d",
                   $time, rsp_if.status, rsp_if.position, rsp_if.entry_count);
          mismatch_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_if.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, rsp_if.status);
            mismatch_count++;
          end
          if (rsp_if.position !== want.position) begin
            $display("%0t: position mismatch: expected %0d actual %0d",
                     $time, want.position, rsp_if.position);
            mismatch_count++;
          end
          if (rsp_if.entry_count !== want.entry_count) begin
            $display("%0t: entry count mismatch: expected %0d actual %0d",
                     $time, want.entry_count, rsp_if.entry_count);
            mismatch_count++;
          end
        end
      end
      if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("[device_address_allow_table] ERROR");
        $finish;
      end
    end
  end

  initial begin
    phase_e     phase;
    allow_rsp_t no_want;

    rst_ni                = 1'b0;
    clk_i                 = 1'b0;
    cmd_if.valid          = 1'b0;
    cmd_if.command        = CMD_LOOKUP;
    cmd_if.device_address = '0;
    mismatch_count        = 0;
    idle_cycles           = 0;
    shadow_count          = 0;
    quiet                 = 1'b0;
    gap_pct               = 25;
    stall_pct             = 25;
    no_want               = '0;

    foreach (recent_pool[i]) recent_pool[i] = random_address();

    // Directed rows. Expectations typed in where obvious; rest from shadow.
    add_row(CMD_LOOKUP, '0,               1, STS_ABSENT, 0, 0);  // empty table
    add_row(CMD_UNREG,  ADDR_ONES,        1, STS_ABSENT, 0, 0);  // remove from empty
    add_row(CMD_REG,    '0,               1, STS_OK,     0, 1);
    add_row(CMD_REG,    ADDR_ONES,        1, STS_OK,     1, 2);
    add_row(CMD_REG,    '0,               1, STS_DUP,    0, 2);  // duplicate
    add_row(CMD_SPARE,  ADDR_ONES,        1, STS_OK,     1, 2);  // spare acts as lookup
    add_row(CMD_LOOKUP, 48'h8000_0000_0000, 1, STS_ABSENT, 0, 2);  // top bit only
    // fill to the last slot with single-bit addresses
    for (int k = 0; k < TABLE_DEPTH - 2; k++) begin
      add_row(CMD_REG, 48'h1 << (3 * k + 2), 0, STS_OK, 0, 0);
    end
    add_row(CMD_REG,    48'h5555_5555_5555, 1, STS_FULL, 0, 16);  // table full
    add_row(CMD_REG,    ADDR_ONES,        1, STS_DUP,    1, 16);  // duplicate on full table
    add_row(CMD_SPARE,  48'h1 << 41,      0, STS_OK,     0, 0);   // last slot hit
    add_row(CMD_UNREG,  '0,               1, STS_OK,     0, 15);  // remove head, shift all
    add_row(CMD_UNREG,  48'h1 << 20,      0, STS_OK,     0, 0);   // remove from middle
    add_row(CMD_UNREG,  48'h1 << 41,      0, STS_OK,     0, 0);   // remove tail
    add_row(CMD_REG,    48'hAAAA_AAAA_AAAA, 0, STS_OK,   0, 0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_q[i]) begin
      send_item(directed_q[i].command, directed_q[i].address,
                directed_q[i].typed, directed_q[i].want);
    end

    phase = PH_FILL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        phase     = phase_e'($urandom_range(0, 2));
        gap_pct   = pick_idle_pct();
        stall_pct = pick_idle_pct();
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_item(pick_command(phase), pick_address(), 0, no_want);
    end

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;

    // the watchdog covers a response that never comes
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[device_address_allow_table] OK");
    end else begin
      $display("[device_address_allow_table] ERROR");
    end
    $finish;
  end

endmodule
